// ----- rtl/qls_pkg.sv -----
// ----------------------------------------------------------------------------
// qls_pkg
// Shared constants and sequencer state type for the quicksort sorter.
// ----------------------------------------------------------------------------
package qls_pkg;

  localparam int QLS_DEPTH = 16;
  localparam int QLS_DW    = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_POPW,
    S_PIV,
    S_CMP,
    S_SWP,
    S_SWP2,
    S_FIN,
    S_FIN2,
    S_FIN3,
    S_PSHL,
    S_PSHH,
    S_ERD,
    S_EOUT
  } state_t;

endpackage

// ----- rtl/qls_ram.sv -----
// ----------------------------------------------------------------------------
// qls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qls_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/quicksort_lomuto_sorter.sv -----
// Load: one item per cycle, no result until the item marked last.
// Sort: per range a stack pop, a stack read and a pivot read, then a compare for
//   each element, a swap where needed, the pivot exchange and pushes; bounded by the element store port.
// Emit: a result is presented only once the previous one is taken; next set loads behind the last.
// Reset (rst_n low, synchronous): count, stack pointer, drop flag and output
//   valid cleared; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter
// Collects signed values, sorts them with iterative Lomuto quicksort in RAM
// using a range stack in a second RAM, then emits them in ascending order.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter
  import qls_pkg::*;
#(
  parameter int DEPTH = QLS_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [QLS_DW-1:0] in_value,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [QLS_DW-1:0] out_sorted_value,
  output logic                     out_last_out,
  output logic                     out_overflowed
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = 2 * IW;

  state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     sp_r, sp_nxt;
  logic              drop_r, drop_nxt;
  logic [IW-1:0]     lo_r, lo_nxt;
  logic [IW-1:0]     hi_r, hi_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [IW-1:0]     bnd_r, bnd_nxt;
  logic [QLS_DW-1:0] pivot_r, pivot_nxt;
  logic [QLS_DW-1:0] aj_r, aj_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [QLS_DW-1:0] out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              e_we;
  logic [IW-1:0]     e_waddr;
  logic [QLS_DW-1:0] e_wdata;
  logic [IW-1:0]     e_raddr;
  logic [QLS_DW-1:0] e_rdata;
  logic              s_we;
  logic [IW-1:0]     s_waddr;
  logic [SW-1:0]     s_wdata;
  logic [IW-1:0]     s_raddr;
  logic [SW-1:0]     s_rdata;

  logic              in_acc;
  logic              le_piv;
  logic [IW:0]       j_p1;
  logic [IW:0]       bnd_p1;
  logic [IW:0]       lo_p1;
  logic [CW-1:0]     sp_m1;
  logic [CW-1:0]     cnt_m1;
  logic              stk_room;
  logic              emit_last;

  qls_ram #(.WIDTH(QLS_DW), .DEPTH(DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  qls_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign le_piv   = ($signed(e_rdata) <= $signed(pivot_r));
  assign j_p1     = {1'b0, j_r} + (IW+1)'(1);
  assign bnd_p1   = {1'b0, bnd_r} + (IW+1)'(1);
  assign lo_p1    = {1'b0, lo_r} + (IW+1)'(1);
  assign sp_m1    = sp_r - CW'(1);
  assign cnt_m1   = count_r - CW'(1);
  assign stk_room = (sp_r < CW'(DEPTH));
  assign emit_last = (((CW+1)'(j_r) + (CW+1)'(1)) == {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sp_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    j_r         <= j_nxt;
    bnd_r       <= bnd_nxt;
    pivot_r     <= pivot_nxt;
    aj_r        <= aj_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    drop_nxt      = drop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    bnd_nxt       = bnd_r;
    pivot_nxt     = pivot_r;
    aj_nxt        = aj_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    e_we          = 1'b0;
    e_waddr       = bnd_r;
    e_wdata       = aj_r;
    e_raddr       = j_r;
    s_we          = 1'b0;
    s_waddr       = sp_r[IW-1:0];
    s_wdata       = {lo_r, hi_r};
    s_raddr       = sp_m1[IW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(DEPTH)) begin
            e_we      = 1'b1;
            e_waddr   = count_r[IW-1:0];
            e_wdata   = in_value;
            count_nxt = count_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_in) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        j_nxt = '0;
        if (count_r >= CW'(2)) begin
          s_we      = 1'b1;
          s_waddr   = '0;
          s_wdata   = {{IW{1'b0}}, cnt_m1[IW-1:0]};
          sp_nxt    = CW'(1);
          state_nxt = S_POP;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          j_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt    = s_rdata[SW-1:IW];
        hi_nxt    = s_rdata[IW-1:0];
        j_nxt     = s_rdata[SW-1:IW];
        bnd_nxt   = s_rdata[SW-1:IW];
        e_raddr   = s_rdata[IW-1:0];
        state_nxt = S_PIV;
      end
      S_PIV: begin
        pivot_nxt = e_rdata;
        e_raddr   = j_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        aj_nxt = e_rdata;
        if (le_piv && (bnd_r != j_r)) begin
          e_raddr   = bnd_r;
          state_nxt = S_SWP;
        end else begin
          if (le_piv) begin
            bnd_nxt = bnd_p1[IW-1:0];
          end
          j_nxt   = j_p1[IW-1:0];
          e_raddr = j_p1[IW-1:0];
          if (j_p1 < {1'b0, hi_r}) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SWP: begin
        e_we      = 1'b1;
        e_waddr   = j_r;
        e_wdata   = e_rdata;
        state_nxt = S_SWP2;
      end
      S_SWP2: begin
        e_we    = 1'b1;
        e_waddr = bnd_r;
        e_wdata = aj_r;
        bnd_nxt = bnd_p1[IW-1:0];
        j_nxt   = j_p1[IW-1:0];
        e_raddr = j_p1[IW-1:0];
        if (j_p1 < {1'b0, hi_r}) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        e_raddr = bnd_r;
        if (bnd_r == hi_r) begin
          state_nxt = S_PSHL;
        end else begin
          state_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        e_we      = 1'b1;
        e_waddr   = hi_r;
        e_wdata   = e_rdata;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        e_we      = 1'b1;
        e_waddr   = bnd_r;
        e_wdata   = pivot_r;
        state_nxt = S_PSHL;
      end
      S_PSHL: begin
        if (({1'b0, bnd_r} > lo_p1) && stk_room) begin
          s_we    = 1'b1;
          s_wdata = {lo_r, bnd_r - IW'(1)};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_PSHH;
      end
      S_PSHH: begin
        if ((bnd_p1 < {1'b0, hi_r}) && stk_room) begin
          s_we    = 1'b1;
          s_wdata = {bnd_p1[IW-1:0], hi_r};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_ERD: begin
        e_raddr = j_r;
        if (!out_valid_r) begin
          state_nxt = S_EOUT;
        end
      end
      S_EOUT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = e_rdata;
        out_last_nxt  = emit_last;
        out_ovf_nxt   = drop_r;
        if (emit_last) begin
          count_nxt = '0;
          sp_nxt    = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          j_nxt     = j_p1[IW-1:0];
          state_nxt = S_ERD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflowed   = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above capacity");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(DEPTH))
    else $error("range stack pointer above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((j_r < hi_r) && (bnd_r <= j_r)))
    else $error("partition scan outside its range");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT) |-> !out_valid_r)
    else $error("result captured over a pending item");
`endif

endmodule

// ----- verif/quicksort_lomuto_sorter_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter_checker
// Watches both channels of the sorter. Collects accepted items, up to the
// store depth, into its own copy of the set, orders it when the closing item
// arrives, and compares every accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_checker
  import qls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [QLS_DW-1:0] in_value,
  input  logic                     in_last_in,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [QLS_DW-1:0] out_sorted_value,
  input  logic                     out_last_out,
  input  logic                     out_overflowed,
  output int                       fail_count,
  output int                       due_count
);

  typedef struct packed {
    logic signed [QLS_DW-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  logic signed [QLS_DW-1:0] held_set [QLS_DEPTH];
  int                       held_n;
  logic                     set_dropped;
  sorted_item_t             sorted_due [$];
  int                       errs;
  int                       results_seen;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR: result %0d %s got %0d want %0d", results_seen, what, got, want);
    errs++;
  endtask

  // Insertion sort of the held set, then queue one result per element.
  task automatic close_set();
    logic signed [QLS_DW-1:0] ordered [QLS_DEPTH];
    logic signed [QLS_DW-1:0] key;
    sorted_item_t             item;
    int                       j;
    for (int i = 0; i < held_n; i++) begin
      key = held_set[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int i = 0; i < held_n; i++) begin
      item.value = ordered[i];
      item.last  = (i == held_n - 1);
      item.ovf   = set_dropped;
      sorted_due.push_back(item);
    end
    held_n      = 0;
    set_dropped = 1'b0;
  endtask

  task automatic take_item(input logic signed [QLS_DW-1:0] v, input logic l);
    if (held_n < QLS_DEPTH) begin
      held_set[held_n] = v;
      held_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (l) close_set();
  endtask

  task automatic check_result();
    sorted_item_t want;
    if (sorted_due.size() == 0) begin
      report_mismatch("sorted_value with none due", out_sorted_value, 0);
    end else begin
      want = sorted_due.pop_front();
      if (out_sorted_value !== want.value)
        report_mismatch("sorted_value", out_sorted_value, want.value);
      if (out_last_out !== want.last)
        report_mismatch("last_out", out_last_out, want.last);
      if (out_overflowed !== want.ovf)
        report_mismatch("overflowed", out_overflowed, want.ovf);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n      = 0;
      set_dropped = 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_item(in_value, in_last_in);
    end
    fail_count <= errs;
    due_count  <= sorted_due.size();
  end

endmodule

// ----- verif/quicksort_lomuto_sorter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter_tb
// Drives sets of signed items into the sorter: directed extremes, single and
// pair sets, a set that overflows the store, then random sets of mixed
// shapes under several idle and stall mixes and one long output hold-off.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_tb;
  import qls_pkg::*;

  localparam int                       CYCLE_LIMIT  = 400000;
  localparam int                       HOLD_CYCLES  = 400;
  localparam int                       PHASE_ITEMS  = 66;
  localparam logic signed [QLS_DW-1:0] VAL_MAX      = 32'sh7FFFFFFF;
  localparam logic signed [QLS_DW-1:0] VAL_MIN      = 32'sh80000000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [QLS_DW-1:0] in_value   = '0;
  logic                     in_last_in = 1'b0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic signed [QLS_DW-1:0] out_sorted_value;
  logic                     out_last_out;
  logic                     out_overflowed;

  int fail_count;
  int due_count;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;
  int items_sent  = 0;

  always #5 clk = ~clk;

  quicksort_lomuto_sorter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflowed   (out_overflowed)
  );

  quicksort_lomuto_sorter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflowed   (out_overflowed),
    .fail_count       (fail_count),
    .due_count        (due_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Called just after a rising edge; returns once the item is accepted and in_stall is low, after any idle gap.
  task automatic offer(input logic signed [QLS_DW-1:0] v, input logic l);
    in_valid   <= 1'b1;
    in_value   <= v;
    in_last_in <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_set(input int n, input int shape);
    logic signed [QLS_DW-1:0] base;
    logic signed [QLS_DW-1:0] step;
    logic signed [QLS_DW-1:0] v;
    base = $urandom;
    step = $urandom_range(1, 5000);
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: v = $urandom;
        1: v = $signed($urandom_range(8)) - 4;
        2: v = base + i * step;
        3: v = base - i * step;
        4: v = base;
        default: begin
          case ($urandom_range(4))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            3: v = -1;
            default: v = $urandom;
          endcase
        end
      endcase
      offer(v, i == n - 1);
    end
  endtask

  task automatic run_phase(input int target, input bit full_sets);
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < target) begin
      if (full_sets) n = $urandom_range(QLS_DEPTH - 2, QLS_DEPTH + 2);
      else if ($urandom_range(99) < 80) n = $urandom_range(1, QLS_DEPTH);
      else n = $urandom_range(QLS_DEPTH + 1, QLS_DEPTH + 4);
      send_set(n, $urandom_range(5));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single item, a pair of extremes, extremes with a duplicate
    offer('0, 1'b1);
    offer(VAL_MAX, 1'b0);
    offer(VAL_MIN, 1'b1);
    offer(-1, 1'b0);
    offer(VAL_MAX, 1'b0);
    offer('0, 1'b0);
    offer(VAL_MIN, 1'b0);
    offer(1, 1'b0);
    offer(VAL_MAX, 1'b1);
    // full store of ascending items, closing item dropped
    for (int i = 0; i < QLS_DEPTH; i++) offer(i - 8, 1'b0);
    offer(VAL_MIN, 1'b1);

    run_phase(PHASE_ITEMS - 26, 1'b0);

    idle_pct  = 70;
    stall_pct <= 0;
    run_phase(PHASE_ITEMS, 1'b0);

    idle_pct  = 0;
    stall_pct <= 70;
    run_phase(PHASE_ITEMS, 1'b0);

    idle_pct  = 18;
    stall_pct <= 18;
    run_phase(PHASE_ITEMS, 1'b0);

    // output held off while full sets keep coming
    idle_pct  = 0;
    stall_pct <= 0;
    hold_req  <= hold_req + 1;
    run_phase(PHASE_ITEMS, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qls_pkg.sv
rtl/qls_ram.sv
rtl/quicksort_lomuto_sorter.sv
verif/quicksort_lomuto_sorter_checker.sv
verif/quicksort_lomuto_sorter_tb.sv
